// ===== rtl/core/mmn_pkg.sv =====
// Shared constants, types and state codes of the min-max normalizer.
package mmn_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int QUO_BITS = 16;
	localparam int CNT_BITS = $clog2(QUO_BITS + 1);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [QUO_BITS-1:0] quo_t;
	typedef logic [FIELD_BITS-1:0] field_t;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_NORMALIZE = 1'b1;

	localparam quo_t NORM_MAX = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/mmn_ifs.sv =====
// Valid/ready stream interfaces for the sample words and the result words.
interface mmn_in_if
	import mmn_pkg::*;
	();
	logic valid;
	logic ready;
	logic operation;
	field_t sample;
	logic last;

	modport source(output valid, output operation, output sample, output last, input ready);
	modport sink(input valid, input operation, input sample, input last, output ready);
endinterface

interface mmn_out_if
	import mmn_pkg::*;
	();
	logic valid;
	logic ready;
	field_t normalized;
	logic zero_range;
	logic out_of_range;
	logic column_end;

	modport source(output valid, output normalized, output zero_range, output out_of_range,
		output column_end, input ready);
	modport sink(input valid, input normalized, input zero_range, input out_of_range,
		input column_end, output ready);
endinterface

// ===== rtl/core/mmn_divider.sv =====
// Restoring divider that produces one quotient bit per cycle, saturating at full scale.
module mmn_divider
	import mmn_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  sample_t diff,
	input  sample_t divisor,
	output logic    done,
	output quo_t    quotient
);

	sample_t rem_q;
	logic [SAMPLE_BITS:0] rem_sh;
	logic [SAMPLE_BITS:0] rem_sub;
	sample_t divisor_q;
	quo_t quo_q;
	logic sat_q;
	logic busy_q;
	logic [CNT_BITS-1:0] count_q;
	logic fits;

	// The partial remainder stays below the divisor, so the shifted value fits one extra bit.
	assign rem_sh = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, divisor_q};
	assign fits = (rem_sh >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			count_q <= CNT_BITS'(QUO_BITS);
		end else if (busy_q) begin
			count_q <= count_q - CNT_BITS'(1);
			if (count_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= diff;
			divisor_q <= divisor;
			sat_q <= (diff == divisor);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], fits};
		end
	end

	assign done = busy_q && (count_q == CNT_BITS'(1));
	// A sample equal to the maximum gives a quotient of exactly one, which clips.
	assign quotient = sat_q ? NORM_MAX : quo_q;

endmodule

// ===== rtl/core/min_max_normalizer_top.sv =====
// Top level of the min-max normalizer: scan and normalize passes over one attribute column.
//
// Each column is streamed twice through the samples channel. A scan word (operation 0)
// updates the running minimum and maximum and is taken in the idle state; it produces no
// result word. A normalize word (operation 1) yields one result word holding
// floor((sample - min) * 65536 / (max - min)) as an unsigned Q0.16 fraction, clipped to
// 65535. A sample below the minimum gives 0 and sets out_of_range; a sample above the
// maximum gives 65535 and sets out_of_range. When the maximum does not exceed the minimum,
// including a column that was never scanned, the result is 0 with zero_range set. A
// normalize word with last set returns the running minimum and maximum to full scale and
// zero for the next column, and its result carries column_end. A normalize word that
// needs a division loads the bit-serial restoring divider at acceptance, which then
// develops one quotient bit per cycle; the result register loads once the divider is
// done and the output register is free, and only then is the input ready again. The
// other normalize words go to the done state at acceptance and load the result
// register from there once the output register is free; the input waits meanwhile.
// The result sits in an output register, so the next sample word is accepted while a
// result still waits to be taken; only a following normalize word that finishes
// before that result is taken stalls the input.
module min_max_normalizer_top
	import mmn_pkg::*;
(
	input logic clk,
	input logic arst_n,
	mmn_in_if.sink samples,
	mmn_out_if.source results
);

	state_t state_q;
	state_t state_d;

	sample_t min_q;
	sample_t max_q;
	sample_t s;
	sample_t diff;
	sample_t divisor;

	logic accept;
	logic out_free;
	logic div_start;
	logic div_done;
	logic load_out;
	quo_t div_quotient;

	logic cls_zr;
	logic cls_oor;
	logic cls_div;
	quo_t cls_norm;

	logic zr_q;
	logic oor_q;
	logic end_q;
	logic use_div_q;
	quo_t pend_norm_q;

	logic out_valid_q;
	quo_t out_norm_q;
	logic out_zr_q;
	logic out_oor_q;
	logic out_end_q;

	// The sample is narrowed or widened to the tracked width, which also masks it.
	assign s = SAMPLE_BITS'(samples.sample);
	assign diff = s - min_q;
	assign divisor = max_q - min_q;

	assign samples.ready = (state_q == ST_IDLE);
	assign accept = samples.valid && samples.ready;
	assign out_free = !out_valid_q || results.ready;

	// Sort the normalize word into its special cases; only in-range samples over a
	// positive range go through the divider.
	always_comb begin
		cls_zr = 1'b0;
		cls_oor = 1'b0;
		cls_div = 1'b0;
		cls_norm = '0;
		if (max_q < min_q) begin
			cls_zr = 1'b1;
		end else if (max_q == min_q) begin
			cls_zr = 1'b1;
			cls_oor = (s != min_q);
		end else if (s < min_q) begin
			cls_oor = 1'b1;
		end else if (s > max_q) begin
			cls_oor = 1'b1;
			cls_norm = NORM_MAX;
		end else begin
			cls_div = 1'b1;
		end
	end

	// Running extremes. The end of a column restores them at acceptance; the divider
	// takes its own copy of the operands at that same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '1;
			max_q <= '0;
		end else if (accept) begin
			if (samples.operation == OP_SCAN) begin
				if (s > max_q) begin
					max_q <= s;
				end
				if (s < min_q) begin
					min_q <= s;
				end
			end else if (samples.last) begin
				min_q <= '1;
				max_q <= '0;
			end
		end
	end

	// Flags of the word in flight, held until the result register takes them.
	always_ff @(posedge clk) begin
		if (accept && (samples.operation == OP_NORMALIZE)) begin
			zr_q <= cls_zr;
			oor_q <= cls_oor;
			end_q <= samples.last;
			use_div_q <= cls_div;
			pend_norm_q <= cls_norm;
		end
	end

	mmn_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.diff     (diff),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (samples.operation == OP_NORMALIZE)) begin
					if (cls_div) begin
						div_start = 1'b1;
						state_d = ST_DIVIDE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register: holds a finished result word until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_norm_q <= use_div_q ? div_quotient : pend_norm_q;
			out_zr_q <= zr_q;
			out_oor_q <= oor_q;
			out_end_q <= end_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.normalized = FIELD_BITS'(out_norm_q);
	assign results.zero_range = out_zr_q;
	assign results.out_of_range = out_oor_q;
	assign results.column_end = out_end_q;

	// A zero range always forces the fraction to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_zr_q) |-> (out_norm_q == '0))
		else $error("zero range result with nonzero fraction");

	// Out-of-range samples over a positive range are clipped to one end of the scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_oor_q && !out_zr_q) |->
		((out_norm_q == '0) || (out_norm_q == NORM_MAX)))
		else $error("out-of-range result not clipped");

	// The divider only finishes while the controller is waiting for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIVIDE))
		else $error("divider finished outside the divide state");

	// The end of a column restores the extremes for the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (samples.operation == OP_NORMALIZE) && samples.last) |=>
		((min_q == '1) && (max_q == '0)))
		else $error("extremes not restored at end of column");

endmodule
